// ----- hw/rtl/tdfp_pkg.sv -----
// Package for the tagged decimal field parser.
// Holds the word types, tag characters, the parse mode type and small helpers.
// No dependencies.
package tdfp_pkg;

    // Word types for the two streaming channels.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [23:0] scaled_value;
    } out_word_t;

    localparam int ACC_W   = 24;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = ACC_W + SCALE_W;

    // Configuration port.
    localparam int  APB_ADDR_W = 3;
    localparam int  APB_DATA_W = 32;
    localparam logic REG_IDX_SCALE = 1'b0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd405789;

    // Tag and digit characters.
    localparam logic [7:0] CHR_OPEN_A  = 8'd65;
    localparam logic [7:0] CHR_CLOSE_B = 8'd66;
    localparam logic [7:0] CHR_OPEN_C  = 8'd67;
    localparam logic [7:0] CHR_CLOSE_D = 8'd68;
    localparam logic [7:0] CHR_OPEN_E  = 8'd69;
    localparam logic [7:0] CHR_CLOSE_F = 8'd70;
    localparam logic [7:0] CHR_OPEN_G  = 8'd71;
    localparam logic [7:0] CHR_CLOSE_H = 8'd72;
    localparam logic [7:0] CHR_ZERO    = 8'd48;
    localparam logic [7:0] CHR_NINE    = 8'd57;

    // Hunting, or inside the field of one channel.
    typedef enum logic [2:0] {
        MODE_HUNT = 3'd0,
        MODE_CH0  = 3'd1,
        MODE_CH1  = 3'd2,
        MODE_CH2  = 3'd3,
        MODE_CH3  = 3'd4
    } mode_t;

    // Closing tag that ends a field of the given channel.
    function automatic logic [7:0] close_tag(input logic [1:0] ch);
        logic [7:0] tag;
        case (ch)
            2'd0:    tag = CHR_CLOSE_B;
            2'd1:    tag = CHR_CLOSE_D;
            2'd2:    tag = CHR_CLOSE_F;
            default: tag = CHR_CLOSE_H;
        endcase
        return tag;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_NINE);
    endfunction

endpackage

// ----- hw/rtl/tdfp_apb.sv -----
// APB-style configuration port of the tagged decimal field parser.
// Holds the scale register. Depends on tdfp_pkg.
module tdfp_apb
    import tdfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SCALE_W-1:0]    scale
);

    logic [SCALE_W-1:0] scale_reg;
    logic               word_idx;
    logic               wr_en;

    // Registers are 32-bit words; the word index sits above the byte offset.
    assign word_idx = paddr[APB_ADDR_W-1];
    assign wr_en    = psel && penable && pwrite && (word_idx == REG_IDX_SCALE);
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (wr_en) begin
            scale_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (word_idx)
            REG_IDX_SCALE: prdata = scale_reg;
            default:       prdata = '0;
        endcase
    end

    assign scale = scale_reg;

endmodule

// ----- hw/rtl/tdfp_parse.sv -----
// Parse state machine of the tagged decimal field parser.
// Hunts for tags, accumulates digits and flags completed fields. Depends on tdfp_pkg.
module tdfp_parse
    import tdfp_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  in_word_t         word,
    output logic             emit,
    output logic [1:0]       channel,
    output logic [ACC_W-1:0] acc
);

    localparam int CNT_W = $clog2(MAX_DIGITS);

    mode_t            mode_reg, mode_next, mode_eff;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W:0]   cnt_inc;
    logic [ACC_W-1:0] acc_digit;
    logic [1:0]       field_ch;

    // A first byte of a buffer is always seen in hunting mode.
    assign mode_eff  = word.first_of_buffer ? MODE_HUNT : mode_reg;
    assign field_ch  = 2'(3'(mode_eff) - 3'd1);
    assign cnt_inc   = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1);
    assign acc_digit = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(word.byte_value[3:0]);

    // Next state.
    always_comb begin
        mode_next = mode_eff;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        unique case (mode_eff)
            MODE_CH0, MODE_CH1, MODE_CH2, MODE_CH3: begin
                if (word.byte_value == close_tag(field_ch)) begin
                    mode_next = MODE_HUNT;
                end else if (is_digit(word.byte_value)) begin
                    acc_next = acc_digit;
                    cnt_next = CNT_W'(cnt_inc);
                    // Reaching the digit limit drops the field.
                    if (cnt_inc == (CNT_W+1)'(MAX_DIGITS)) begin
                        mode_next = MODE_HUNT;
                    end
                end else begin
                    // A foreign byte drops the field and is consumed.
                    mode_next = MODE_HUNT;
                end
            end
            default: begin
                mode_next = MODE_HUNT;
                if (word.byte_value == CHR_OPEN_A || word.byte_value == CHR_OPEN_C ||
                    word.byte_value == CHR_OPEN_E || word.byte_value == CHR_OPEN_G) begin
                    mode_next = mode_t'(3'(word.byte_value[2:1]) + 3'd1);
                    cnt_next  = '0;
                    acc_next  = '0;
                end
            end
        endcase
    end

    // Outputs.
    always_comb begin
        emit    = 1'b0;
        channel = field_ch;
        unique case (mode_eff)
            MODE_CH0, MODE_CH1, MODE_CH2, MODE_CH3: begin
                emit = (word.byte_value == close_tag(field_ch));
            end
            default: begin
                emit    = 1'b0;
                channel = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HUNT;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

    a_emit_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && emit) |=> (mode_reg == MODE_HUNT))
        else $error("parser did not return to hunting after a closing tag");

    a_count_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_HUNT) |-> ((CNT_W+1)'(cnt_reg) < (CNT_W+1)'(MAX_DIGITS)))
        else $error("digit count reached the limit inside a field");

endmodule

// ----- hw/rtl/tdfp_scale.sv -----
// Result stage of the tagged decimal field parser.
// Scales the finished value by the Q0.32 factor into the result register. Depends on tdfp_pkg.
module tdfp_scale
    import tdfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [1:0]         channel,
    input  logic [ACC_W-1:0]   acc,
    input  logic [SCALE_W-1:0] scale,
    input  logic               m_ready,
    output logic               m_valid,
    output out_word_t          m_data,
    output logic               slot_free
);

    logic              valid_reg, valid_next;
    out_word_t         data_reg;
    logic [PROD_W-1:0] prod;

    assign prod      = PROD_W'(acc) * PROD_W'(scale);
    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.channel      <= channel;
            data_reg.scaled_value <= prod[PROD_W-1 -: ACC_W];
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> slot_free)
        else $error("result register overwritten before it was taken");

endmodule

// ----- hw/rtl/tagged_decimal_field_parser.sv -----
// Top level of the tagged decimal field parser.
// Instantiates tdfp_apb, tdfp_parse and tdfp_scale; depends on tdfp_pkg.
//
// The parser takes a rangefinder byte stream, one byte per word on the s_ channel. While
// hunting it waits for an opening tag 'A', 'C', 'E' or 'G', which selects channel 0 to 3,
// then collects ASCII decimal digits until the matching closing tag 'B', 'D', 'F' or 'H'.
// At the closing tag it sends one word on the m_ channel carrying the channel and the
// collected value multiplied by scale_q32 / 2^32, truncated; an empty field gives 0. A field
// is dropped without a result when it reaches MAX_DIGITS digits or when any other byte shows
// up inside it, and that byte is not taken as a new opening tag. A byte flagged as the first
// of a buffer always puts the parser back into hunting before it is looked at. The block
// takes one word per clock cycle unless a closing tag waits on a full output register:
// each word passes through an input register, where the parse state machine consumes it,
// and a result goes from there into the output register, where the 24 by 32 bit scaling
// multiply sits. Bytes that give no result move on, and the input keeps accepting, even
// while a result waits in the full output register. scale_q32 lives at byte address 0 of
// the APB port and should only be written while the stream is idle.
module tagged_decimal_field_parser
    import tdfp_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Byte stream in.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // Results out.
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    // Configuration.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic               in_valid_reg, in_valid_next;
    in_word_t           in_word_reg;
    logic               step;
    logic               emit;
    logic               slot_free;
    logic [1:0]         channel;
    logic [ACC_W-1:0]   acc;
    logic [SCALE_W-1:0] scale;

    tdfp_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .scale   (scale)
    );

    // The held word is consumed when it yields nothing, or when the result register can
    // take its result this cycle.
    assign step    = in_valid_reg && (slot_free || !emit);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    tdfp_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .word    (in_word_reg),
        .emit    (emit),
        .channel (channel),
        .acc     (acc)
    );

    tdfp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && emit),
        .channel   (channel),
        .acc       (acc),
        .scale     (scale),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .slot_free (slot_free)
    );

    // A word stalled at the input means the input register is occupied.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stalled with an empty input register");

endmodule

// ----- bench/testbench.sv -----
// Testbench for tagged_decimal_field_parser: streams tagged decimal fields and checks each
// result word against a field-by-field prediction of channel and scaled value.
// Depends on tdfp_pkg and the parser RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;
    import tdfp_pkg::*;

    localparam int FIELD_MAX_DIGITS = 8;
    localparam int DRAIN_CYCLES     = 10;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASE_WORDS      = 250;
    localparam int NUM_PHASES       = 5;
    localparam logic [APB_ADDR_W-1:0] SCALE_ADDR = APB_ADDR_W'(4 * REG_IDX_SCALE);

    // Tracks the parser state, predicts the result words and checks them in order.
    class field_scoreboard;
        logic [SCALE_W-1:0] scale;
        mode_t              mode;
        logic [2:0]         digits;
        logic [ACC_W-1:0]   acc;
        out_word_t          pending_q[$];
        int                 mismatches;

        function new();
            scale      = SCALE_RESET;
            mode       = MODE_HUNT;
            digits     = 3'd0;
            acc        = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Advances the predicted state by one accepted input word.
        function void note_byte(in_word_t w);
            logic [7:0]        b;
            logic [1:0]        ch;
            logic [PROD_W-1:0] product;
            out_word_t         res;
            b = w.byte_value;
            if (w.first_of_buffer) mode = MODE_HUNT;
            if (mode == MODE_HUNT) begin
                case (b)
                    CHR_OPEN_A: mode = MODE_CH0;
                    CHR_OPEN_C: mode = MODE_CH1;
                    CHR_OPEN_E: mode = MODE_CH2;
                    CHR_OPEN_G: mode = MODE_CH3;
                    default: ;
                endcase
                if (mode != MODE_HUNT) begin
                    digits = 3'd0;
                    acc    = '0;
                end
                return;
            end
            ch = 2'(mode - MODE_CH0);
            if (b == 8'(CHR_CLOSE_B + 2 * ch)) begin
                product          = PROD_W'(acc) * PROD_W'(scale);
                res.channel      = ch;
                res.scaled_value = product[PROD_W-1:SCALE_W];
                pending_q.push_back(res);
                mode = MODE_HUNT;
            end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
                acc    = ACC_W'(acc * 10 + (b - CHR_ZERO));
                digits = digits + 3'd1;
                // The counter is three bits wide, so a limit of eight shows up as a wrap to zero.
                if (digits == 3'(FIELD_MAX_DIGITS % 8)) mode = MODE_HUNT;
            end else begin
                mode = MODE_HUNT;
            end
        endfunction

        task check_result(out_word_t got);
            out_word_t want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word: channel %0d value %0d",
                                          got.channel, got.scaled_value));
                return;
            end
            want = pending_q.pop_front();
            if (got.channel !== want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d",
                                          got.channel, want.channel));
            if (got.scaled_value !== want.scaled_value)
                report_mismatch($sformatf("scaled value %0d, expected %0d",
                                          got.scaled_value, want.scaled_value));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    field_scoreboard sb;
    bit              calm         = 1'b0;
    bit              hold_request = 1'b0;
    int              sent_words   = 0;
    int              cycles       = 0;

    tagged_decimal_field_parser #(
        .MAX_DIGITS(FIELD_MAX_DIGITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // Run limit: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. Ready idles in random bursts, takes one long hold-off on request so that
    // the parser backs up and stalls its input, and stays high once the run turns calm.
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Every word taken on the result channel is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Offers one word, possibly after a random idle burst, and waits for its handshake.
    // Valid is left high so the next word can follow back to back.
    task automatic send_word(input logic [7:0] b, input logic first);
        in_word_t w;
        int       gap;
        w.byte_value      = b;
        w.first_of_buffer = first;
        gap = 0;
        if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(w);
        sent_words++;
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++) send_word(txt[k], 1'b0);
    endtask

    // One field with random content: some noise ahead of it, a random channel and digit count,
    // and now and then a foreign byte, a buffer restart or the closing tag of another channel.
    task automatic send_random_frame();
        logic [1:0] ch;
        logic [1:0] other;
        logic [7:0] b;
        int         n_digits;
        int         fault;
        int         fault_at;
        ch    = 2'($urandom_range(0, 3));
        other = ch + 2'd1;
        repeat ($urandom_range(0, 2))
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 19))
            0:       n_digits = 0;
            1:       n_digits = $urandom_range(8, 10);
            default: n_digits = $urandom_range(1, 7);
        endcase
        fault    = $urandom_range(0, 11);
        fault_at = $urandom_range(0, n_digits);
        send_word(8'(CHR_OPEN_A + 2 * ch), $urandom_range(0, 7) == 0);
        for (int k = 0; k <= n_digits; k++) begin
            if (k < n_digits) b = 8'(CHR_ZERO + $urandom_range(0, 9));
            else if (fault == 2) b = 8'(CHR_CLOSE_B + 2 * other);
            else b = 8'(CHR_CLOSE_B + 2 * ch);
            if (fault == 0 && k == fault_at) b = 8'($urandom_range(0, 255));
            send_word(b, fault == 1 && k == fault_at);
        end
    endtask

    // Drops valid, waits for every predicted word, then lets the pipeline empty out since
    // the last words may have produced no result.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCALE_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.scale = value;
    endtask

    initial begin
        logic [SCALE_W-1:0] phase_scale [NUM_PHASES];
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed fields at full scale: an empty field, the longest kept value, a field
        // that hits the digit limit, a foreign byte that is swallowed rather than opening a
        // field, and a buffer restart in the middle of a field.
        write_scale('1);
        send_text("AB");
        send_text("G9999999H");
        send_text("C11111111");
        send_text("EA");
        send_text("C4");
        send_word(CHR_OPEN_G, 1'b1);
        send_text("H");
        settle();

        phase_scale[0] = SCALE_RESET;
        phase_scale[1] = '0;
        phase_scale[2] = SCALE_W'($urandom);
        phase_scale[3] = 32'h8000_0000;
        phase_scale[4] = '1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_scale(phase_scale[p]);
            if (p == 2) hold_request = 1'b1;
            if (p == NUM_PHASES - 1) calm = 1'b1;
            while (sent_words < (p + 1) * PHASE_WORDS) send_random_frame();
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/tdfp_pkg.sv
hw/rtl/tdfp_apb.sv
hw/rtl/tdfp_parse.sv
hw/rtl/tdfp_scale.sv
hw/rtl/tagged_decimal_field_parser.sv
bench/testbench.sv
